@@ hw/rtl/awfd_pkg.sv @@
// Shared types and constants of the acoustic wave stencil core.
// Item structs, configuration register indexes and the saturation helper.
// No dependencies.
package awfd_pkg;

    localparam int STORE_ROWS = 5;
    localparam int NOPS       = 9;
    localparam int CMP_W      = 14;

    // Operand slots of one stencil job.
    localparam int OP_C   = 0;
    localparam int OP_ZM1 = 1;
    localparam int OP_ZP1 = 2;
    localparam int OP_ZM2 = 3;
    localparam int OP_ZP2 = 4;
    localparam int OP_XM1 = 5;
    localparam int OP_XP1 = 6;
    localparam int OP_XM2 = 7;
    localparam int OP_XP2 = 8;

    // Configuration register indexes.
    localparam logic [3:0] CFG_COEF_CENTER = 4'd0;
    localparam logic [3:0] CFG_COEF_Z_NEAR = 4'd1;
    localparam logic [3:0] CFG_COEF_Z_FAR  = 4'd2;
    localparam logic [3:0] CFG_COEF_X_NEAR = 4'd3;
    localparam logic [3:0] CFG_COEF_X_FAR  = 4'd4;
    localparam logic [3:0] CFG_ROWS_LENGTH = 4'd5;
    localparam logic [3:0] CFG_ROWS_COUNT  = 4'd6;
    localparam logic [3:0] CFG_BACKWARD    = 4'd7;

    typedef struct packed {
        logic               frame_start;
        logic signed [31:0] p1_sample;
        logic signed [31:0] p0_center;
        logic        [30:0] vel_sq_center;
        logic        [30:0] illum_center;
    } t_in;

    typedef struct packed {
        logic        [9:0]  center_x;
        logic        [9:0]  center_z;
        logic signed [31:0] p_next;
        logic signed [31:0] laplacian;
        logic        [30:0] illum_next;
    } t_out;

    typedef struct packed {
        logic signed [31:0] coef_center;
        logic signed [31:0] coef_z_near;
        logic signed [31:0] coef_z_far;
        logic signed [31:0] coef_x_near;
        logic signed [31:0] coef_x_far;
        logic        [10:0] rows_length;
        logic        [10:0] rows_count;
        logic               backward_mode;
    } t_cfg;

    typedef struct packed {
        logic [9:0]             center_x;
        logic [9:0]             center_z;
        logic [NOPS-1:0][31:0]  ops;
        logic signed [31:0]     p0;
        logic [30:0]            vv;
        logic [30:0]            il;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/awfd_queue.sv @@
// Two-entry job queue between the stencil front end and the arithmetic back end.
// Depends on awfd_pkg for the job type.
module awfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  awfd_pkg::t_job i_data,
    input  logic           i_pop,
    output awfd_pkg::t_job o_data,
    output logic           o_full,
    output logic           o_empty
);
    import awfd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not follow a push");

endmodule

@@ hw/rtl/awfd_front.sv @@
// Front end: tracks the raster position, keeps the five-row line store and
// gathers the stencil neighbours of each interior point into a job.
// Depends on awfd_pkg.
module awfd_front #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_ROW_COUNT  = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  awfd_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  awfd_pkg::t_in  i_in_data,
    output logic           o_push,
    output awfd_pkg::t_job o_job,
    input  logic           i_full
);
    import awfd_pkg::*;

    localparam int LW = $clog2(MAX_ROW_LENGTH);
    localparam int XW = $clog2(MAX_ROW_COUNT);
    localparam int AW = $clog2(STORE_ROWS * MAX_ROW_LENGTH);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_PUSH} t_state;

    t_state             r_state;
    logic [3:0]         r_rd_idx;
    logic [XW-1:0]      r_x;
    logic [LW-1:0]      r_z;
    logic [2:0]         r_slot;
    logic [2:0]         r_cur_slot;
    logic [LW-1:0]      r_cur_z;
    t_job               r_job;
    logic [31:0]        r_q;
    logic [31:0]        r_mem [STORE_ROWS * MAX_ROW_LENGTH];

    logic [CMP_W-1:0]   len;
    logic [CMP_W-1:0]   cnt;
    logic [XW-1:0]      x;
    logic [LW-1:0]      z0;
    logic [LW-1:0]      z;
    logic [2:0]         slot;
    logic               accept;
    logic               interior;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic [2:0]         back;
    logic [2:0]         rd_slot;
    logic [LW-1:0]      rd_z;

    always_comb begin
        len = CMP_W'(i_cfg.rows_length);
        if (len < CMP_W'(5)) begin
            len = CMP_W'(5);
        end else if (len > CMP_W'(MAX_ROW_LENGTH)) begin
            len = CMP_W'(MAX_ROW_LENGTH);
        end
        cnt = CMP_W'(i_cfg.rows_count);
        if (cnt < CMP_W'(5)) begin
            cnt = CMP_W'(5);
        end else if (cnt > CMP_W'(MAX_ROW_COUNT)) begin
            cnt = CMP_W'(MAX_ROW_COUNT);
        end
    end

    // A shorter row length written since the last sample pulls z back inside the row.
    always_comb begin
        x    = i_in_data.frame_start ? '0 : r_x;
        z0   = i_in_data.frame_start ? '0 : r_z;
        slot = i_in_data.frame_start ? 3'd0 : r_slot;
        z    = (CMP_W'(z0) >= len) ? LW'(len - CMP_W'(1)) : z0;
        interior = (CMP_W'(x) >= CMP_W'(4)) && (CMP_W'(x) < cnt)
                && (CMP_W'(z) >= CMP_W'(2)) && (CMP_W'(z) + CMP_W'(3) <= len);
    end

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign wr_addr    = AW'(slot) * AW'(MAX_ROW_LENGTH) + AW'(z);

    always_comb begin
        unique case (r_rd_idx)
            4'(OP_C):   begin back = 3'd2; rd_z = r_cur_z;          end
            4'(OP_ZM1): begin back = 3'd2; rd_z = r_cur_z - LW'(1); end
            4'(OP_ZP1): begin back = 3'd2; rd_z = r_cur_z + LW'(1); end
            4'(OP_ZM2): begin back = 3'd2; rd_z = r_cur_z - LW'(2); end
            4'(OP_ZP2): begin back = 3'd2; rd_z = r_cur_z + LW'(2); end
            4'(OP_XM1): begin back = 3'd3; rd_z = r_cur_z;          end
            4'(OP_XP1): begin back = 3'd1; rd_z = r_cur_z;          end
            default:    begin back = 3'd4; rd_z = r_cur_z;          end
        endcase
        rd_slot = (r_cur_slot >= back) ? (r_cur_slot - back)
                                       : (r_cur_slot + 3'(STORE_ROWS) - back);
        rd_addr = AW'(rd_slot) * AW'(MAX_ROW_LENGTH) + AW'(rd_z);
        rd_en   = (r_state == S_READ) && (r_rd_idx < 4'(NOPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[wr_addr] <= i_in_data.p1_sample;
        end
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= '0;
            r_x      <= '0;
            r_z      <= '0;
            r_slot   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (CMP_W'(z) + CMP_W'(1) >= len) begin
                            r_z <= '0;
                            if (CMP_W'(x) + CMP_W'(1) >= cnt) begin
                                r_x    <= '0;
                                r_slot <= 3'd0;
                            end else begin
                                r_x    <= x + XW'(1);
                                r_slot <= (slot == 3'(STORE_ROWS - 1)) ? 3'd0 : slot + 3'd1;
                            end
                        end else begin
                            r_z    <= z + LW'(1);
                            r_x    <= x;
                            r_slot <= slot;
                        end
                        if (interior) begin
                            r_job.center_x     <= 10'(x - XW'(2));
                            r_job.center_z     <= 10'(z);
                            r_job.ops[OP_XP2]  <= i_in_data.p1_sample;
                            r_job.p0           <= i_in_data.p0_center;
                            r_job.vv           <= i_in_data.vel_sq_center;
                            r_job.il           <= i_in_data.illum_center;
                            r_cur_slot         <= slot;
                            r_cur_z            <= z;
                            r_rd_idx           <= '0;
                            r_state            <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // Read data arrives in the cycle after its address.
                    if (r_rd_idx != 4'd0) begin
                        r_job.ops[r_rd_idx - 4'd1] <= r_q;
                    end
                    if (r_rd_idx == 4'(NOPS - 1)) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_rd_idx <= r_rd_idx + 4'd1;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_read_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> o_in_stall)
        else $error("line store read while taking items");
    a_push_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> $past(r_state == S_READ || r_state == S_PUSH))
        else $error("job pushed before its operands were gathered");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < 3'(STORE_ROWS))
        else $error("row slot out of range");

endmodule

@@ hw/rtl/awfd_back.sv @@
// Back end: evaluates one stencil job with a single shared multiplier and
// holds the result in an output register. Depends on awfd_pkg.
module awfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  awfd_pkg::t_cfg i_cfg,
    input  awfd_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output awfd_pkg::t_out o_out_data
);
    import awfd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state              r_state;
    logic [2:0]          r_step;
    logic                r_phase;
    t_job                r_job;
    logic signed [50:0]  r_prod;
    logic signed [53:0]  r_acc;
    logic signed [31:0]  r_tmp;
    logic signed [31:0]  r_pn;
    logic signed [31:0]  r_lap;
    logic [30:0]         r_iln;
    logic                r_out_valid;
    t_out                r_out;

    logic signed [32:0]  mul_a;
    logic signed [33:0]  mul_b;
    logic signed [66:0]  mul_p;
    logic signed [53:0]  acc_sum;
    logic signed [35:0]  lap_sum;
    logic signed [51:0]  pn_sum;
    logic signed [51:0]  il_sum;

    function automatic logic signed [33:0] pair(input logic [31:0] a, input logic [31:0] b);
        return 34'($signed(a)) + 34'($signed(b));
    endfunction

    always_comb begin
        unique case (r_step)
            3'd0: begin
                mul_a = 33'(i_cfg.coef_center);
                mul_b = 34'($signed(r_job.ops[OP_C]));
            end
            3'd1: begin
                mul_a = 33'(i_cfg.coef_z_near);
                mul_b = pair(r_job.ops[OP_ZM1], r_job.ops[OP_ZP1]);
            end
            3'd2: begin
                mul_a = 33'(i_cfg.coef_z_far);
                mul_b = pair(r_job.ops[OP_ZM2], r_job.ops[OP_ZP2]);
            end
            3'd3: begin
                mul_a = 33'(i_cfg.coef_x_near);
                mul_b = pair(r_job.ops[OP_XM1], r_job.ops[OP_XP1]);
            end
            3'd4: begin
                mul_a = 33'(i_cfg.coef_x_far);
                mul_b = pair(r_job.ops[OP_XM2], r_job.ops[OP_XP2]);
            end
            3'd5: begin
                mul_a = $signed({2'b00, r_job.vv});
                mul_b = 34'(r_tmp);
            end
            default: begin
                mul_a = 33'($signed(r_job.ops[OP_C]));
                mul_b = 34'($signed(r_job.ops[OP_C]));
            end
        endcase
        mul_p   = 67'(mul_a) * 67'(mul_b);
        acc_sum = r_acc + 54'(r_prod);
        lap_sum = 36'($signed(r_job.ops[OP_ZM1])) + 36'($signed(r_job.ops[OP_ZP1]))
                + 36'($signed(r_job.ops[OP_XM1])) + 36'($signed(r_job.ops[OP_XP1]))
                - (36'($signed(r_job.ops[OP_C])) <<< 2);
        pn_sum  = (52'($signed(r_job.ops[OP_C])) <<< 1) - 52'(r_job.p0) + 52'(r_prod);
        il_sum  = $signed({21'd0, r_job.il}) + 52'(r_prod);
    end

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded instead of emptied.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_step  <= 3'd0;
                        r_phase <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_phase <= ~r_phase;
                    if (!r_phase) begin
                        // Arithmetic shift floors the exact product, dropping 16 fraction bits.
                        r_prod <= 51'(mul_p >>> 16);
                    end else begin
                        r_step <= r_step + 3'd1;
                        unique case (r_step)
                            3'd0: r_acc <= 54'(r_prod);
                            3'd4: r_tmp <= sat32(64'(acc_sum));
                            3'd5: begin
                                r_pn <= sat32(64'(pn_sum));
                                if (!i_cfg.backward_mode) begin
                                    r_lap   <= '0;
                                    r_iln   <= r_job.il;
                                    r_state <= S_DONE;
                                end
                            end
                            3'd6: begin
                                r_lap   <= sat32(64'(lap_sum));
                                r_iln   <= (il_sum > 52'sd2147483647) ? 31'h7FFFFFFF
                                                                      : il_sum[30:0];
                                r_state <= S_DONE;
                            end
                            default: r_acc <= acc_sum;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.center_x   <= r_job.center_x;
                        r_out.center_z   <= r_job.center_z;
                        r_out.p_next     <= r_pn;
                        r_out.laplacian  <= r_lap;
                        r_out.illum_next <= r_iln;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_RUN))
        else $error("job taken without starting evaluation");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("waiting result dropped");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step != 3'd7))
        else $error("evaluation step out of range");

endmodule

@@ hw/rtl/acoustic_wave_fd_stencil_core.sv @@
// Top level of the 2D acoustic wave stencil core: configuration registers,
// front end, job queue and arithmetic back end. Depends on awfd_pkg.
//
// Usage: current-field samples enter on the input channel in raster order
// (rows outer, samples within a row inner), each with the previous field,
// velocity term and illumination of the point two rows back. An item is
// taken when i_in_valid is high and o_in_stall low; results leave on the
// output channel when o_out_valid is high and i_out_stall low.
// An item whose centre is not interior leaves the front end free for the next
// item. An interior item holds the front end for its eight line store reads
// through one read port and until its job is in the queue; the back end
// evaluates one job at a time in steps on its single shared multiplier, with
// an extra Laplacian and illumination step in backward mode.
// Reset clears the position counters, queue and result register and
// restores the default configuration; the line store is not cleared.
// A stalled result is held; the front end keeps taking items between its gathers
// until the two-entry queue is full, then holds o_in_stall high until its job is pushed.
// Configuration writes are always ready and must occur while idle.
module acoustic_wave_fd_stencil_core #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_ROW_COUNT  = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  awfd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output awfd_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [3:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import awfd_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_center   <= '0;
            r_cfg.coef_z_near   <= '0;
            r_cfg.coef_z_far    <= '0;
            r_cfg.coef_x_near   <= '0;
            r_cfg.coef_x_far    <= '0;
            r_cfg.rows_length   <= 11'd1024;
            r_cfg.rows_count    <= 11'd1024;
            r_cfg.backward_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COEF_CENTER: r_cfg.coef_center   <= i_cfg_data;
                CFG_COEF_Z_NEAR: r_cfg.coef_z_near   <= i_cfg_data;
                CFG_COEF_Z_FAR:  r_cfg.coef_z_far    <= i_cfg_data;
                CFG_COEF_X_NEAR: r_cfg.coef_x_near   <= i_cfg_data;
                CFG_COEF_X_FAR:  r_cfg.coef_x_far    <= i_cfg_data;
                CFG_ROWS_LENGTH: r_cfg.rows_length   <= i_cfg_data[10:0];
                CFG_ROWS_COUNT:  r_cfg.rows_count    <= i_cfg_data[10:0];
                CFG_BACKWARD:    r_cfg.backward_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    awfd_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROW_COUNT  (MAX_ROW_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    awfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    awfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench of the acoustic wave stencil core: random and directed sample
// streams, a bit-true predictor of the stencil update and a scoreboard of expected results.
// Depends on awfd_pkg and acoustic_wave_fd_stencil_core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import awfd_pkg::*;

    typedef logic signed [95:0] t_wide;

    class stencil_scoreboard;
        logic signed [31:0] line_rows [STORE_ROWS][1024];
        int unsigned        row_x;
        int unsigned        row_z;
        t_cfg               regs;
        t_out               pending_q [$];
        int                 errors;

        function new();
            regs = '0;
            regs.rows_length = 11'd1024;
            regs.rows_count  = 11'd1024;
            row_x = 0;
            row_z = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [31:0] val);
            case (idx)
                CFG_COEF_CENTER: regs.coef_center   = val;
                CFG_COEF_Z_NEAR: regs.coef_z_near   = val;
                CFG_COEF_Z_FAR:  regs.coef_z_far    = val;
                CFG_COEF_X_NEAR: regs.coef_x_near   = val;
                CFG_COEF_X_FAR:  regs.coef_x_far    = val;
                CFG_ROWS_LENGTH: regs.rows_length   = val[10:0];
                CFG_ROWS_COUNT:  regs.rows_count    = val[10:0];
                CFG_BACKWARD:    regs.backward_mode = val[0];
                default: ;
            endcase
        endfunction

        // Q16.16 product with the fraction dropped towards minus infinity.
        function t_wide qmul(t_wide a, t_wide b);
            t_wide p;
            p = a * b;
            return p >>> 16;
        endfunction

        function t_wide clip32(t_wide v);
            if (v > 96'sd2147483647) return 96'sd2147483647;
            if (v < -96'sd2147483648) return -96'sd2147483648;
            return v;
        endfunction

        function t_wide neighbour(int unsigned back, int unsigned z);
            return t_wide'(line_rows[(row_x + STORE_ROWS - back) % STORE_ROWS][z]);
        endfunction

        function void note_sample(t_in it);
            int unsigned len;
            int unsigned cnt;
            int unsigned x;
            int unsigned z;
            t_wide c, zs1, zs2, xs1, xs2, acc, upd, lap, ill;
            t_out res;
            len = (regs.rows_length < 5) ? 5 : (regs.rows_length > 1024) ? 1024 : regs.rows_length;
            cnt = (regs.rows_count < 5) ? 5 : (regs.rows_count > 1024) ? 1024 : regs.rows_count;
            if (it.frame_start) begin
                row_x = 0;
                row_z = 0;
            end
            if (row_z >= len) row_z = len - 1;
            x = row_x;
            z = row_z;
            line_rows[x % STORE_ROWS][z] = it.p1_sample;
            if (x >= 4 && x < cnt && z >= 2 && z + 3 <= len) begin
                c   = neighbour(2, z);
                zs1 = neighbour(2, z - 1) + neighbour(2, z + 1);
                zs2 = neighbour(2, z - 2) + neighbour(2, z + 2);
                xs1 = neighbour(3, z) + neighbour(1, z);
                xs2 = neighbour(4, z) + neighbour(0, z);
                acc = qmul(t_wide'(regs.coef_center), c) + qmul(t_wide'(regs.coef_z_near), zs1)
                    + qmul(t_wide'(regs.coef_z_far), zs2) + qmul(t_wide'(regs.coef_x_near), xs1)
                    + qmul(t_wide'(regs.coef_x_far), xs2);
                acc = clip32(acc);
                upd = clip32(2 * c - t_wide'(it.p0_center)
                             + qmul(t_wide'({1'b0, it.vel_sq_center}), acc));
                lap = 0;
                ill = t_wide'({1'b0, it.illum_center});
                if (regs.backward_mode) begin
                    lap = clip32(-4 * c + zs1 + xs1);
                    ill = ill + qmul(c, c);
                    if (ill > 96'sd2147483647) ill = 96'sd2147483647;
                end
                res.center_x   = 10'(x - 2);
                res.center_z   = 10'(z);
                res.p_next     = upd[31:0];
                res.laplacian  = lap[31:0];
                res.illum_next = ill[30:0];
                pending_q.push_back(res);
            end
            if (z + 1 >= len) begin
                row_z = 0;
                row_x = (x + 1 >= cnt) ? 0 : x + 1;
            end else begin
                row_z = z + 1;
            end
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d z=%0d", $time, got.center_x, got.center_z);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.center_x !== exp_r.center_x) begin
                $display("%0t: center_x expected %0d actual %0d", $time,
                         exp_r.center_x, got.center_x);
                errors++;
            end
            if (got.center_z !== exp_r.center_z) begin
                $display("%0t: center_z expected %0d actual %0d", $time,
                         exp_r.center_z, got.center_z);
                errors++;
            end
            if (got.p_next !== exp_r.p_next) begin
                $display("%0t: p_next expected %h actual %h", $time, exp_r.p_next, got.p_next);
                errors++;
            end
            if (got.laplacian !== exp_r.laplacian) begin
                $display("%0t: laplacian expected %h actual %h", $time,
                         exp_r.laplacian, got.laplacian);
                errors++;
            end
            if (got.illum_next !== exp_r.illum_next) begin
                $display("%0t: illum_next expected %h actual %h", $time,
                         exp_r.illum_next, got.illum_next);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out       o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    stencil_scoreboard sb;
    bit  quiet;
    int  hold_cycles;
    bit  sample_seen;

    acoustic_wave_fd_stencil_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("acoustic_wave_fd_stencil_core test failed");
        $finish;
    end

    // Result side: random stall bursts, plus a long hold when the main flow asks for one.
    initial begin
        int burst;
        burst = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(0, 12);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        if ($urandom_range(0, 3) == 0) return pick_word();
        return 32'($signed($urandom_range(0, 262143)) - 131072);
    endfunction

    task automatic cfg_write(logic [3:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [31:0] len, logic [31:0] cnt, bit bwd, bit extreme);
        cfg_write(CFG_COEF_CENTER, extreme ? 32'h8000_0000 : pick_coef());
        cfg_write(CFG_COEF_Z_NEAR, extreme ? 32'h7FFF_FFFF : pick_coef());
        cfg_write(CFG_COEF_Z_FAR,  extreme ? 32'h8000_0000 : pick_coef());
        cfg_write(CFG_COEF_X_NEAR, extreme ? 32'h7FFF_FFFF : pick_coef());
        cfg_write(CFG_COEF_X_FAR,  extreme ? 32'h7FFF_FFFF : pick_coef());
        cfg_write(CFG_ROWS_LENGTH, len);
        cfg_write(CFG_ROWS_COUNT, cnt);
        cfg_write(CFG_BACKWARD, {31'd0, bwd});
    endtask

    task automatic send_sample(t_in it);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(it);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // results-free items may still be in flight
        repeat (40) @(posedge i_clk);
    endtask

    // One phase of samples; the first item of a phase always restarts the grid.
    task automatic stream(int n, bit extremes);
        t_in it;
        for (int i = 0; i < n; i++) begin
            it.frame_start   = (i == 0) || ($urandom_range(0, 299) == 0);
            it.p1_sample     = extremes ? (i[0] ? 32'h7FFF_FFFF : 32'h8000_0000) : pick_word();
            it.p0_center     = extremes ? (i[1] ? 32'h7FFF_FFFF : 32'h8000_0000) : pick_word();
            it.vel_sq_center = extremes ? 31'h7FFF_FFFF : 31'(pick_word());
            it.illum_center  = extremes ? (i[0] ? 31'h7FFF_FFFF : 31'h0) : 31'(pick_word());
            send_sample(it);
        end
    endtask

    initial begin
        int n;
        sb = new();
        quiet = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COEF_CENTER;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest grid, extreme coefficients and samples to force saturation.
        configure(32'd5, 32'd5, 1'b1, 1'b1);
        stream(25, 1'b1);
        drain();
        // Longest row with only part of the first row filled, then clamped sizes and a tall grid.
        configure(32'd1024, 32'd5, 1'b0, 1'b0);
        stream(40, 1'b0);
        drain();
        configure(32'd0, 32'd2047, 1'b1, 1'b0);
        stream(120, 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph == 7);
            configure($urandom_range(5, 20), $urandom_range(5, 12), $urandom_range(0, 1), 1'b0);
            n = 220;
            if (ph == 2) begin
                // Receiver holds off while the sender keeps offering items.
                stream(30, 1'b0);
                hold_cycles = 400;
                stream(190, 1'b0);
            end else if (ph == 4) begin
                stream(110, 1'b0);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge i_clk);
                stream(110, 1'b0);
            end else begin
                stream(n, 1'b0);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("acoustic_wave_fd_stencil_core test passed");
        end else begin
            $display("acoustic_wave_fd_stencil_core test failed");
        end
        $finish;
    end
endmodule
